// ----- src/brb_pkg.sv -----
// Shared types, sizes and operation codes for the byte ring buffer.
package brb_pkg;

    localparam int DEPTH  = 1024;
    localparam int LANES  = 8;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ROWS   = DEPTH / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int LEN_W  = 4;
    localparam int OFF_W  = 11;
    localparam int DATA_W = 64;
    localparam int FILL_W = 11;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [LEN_W-1:0]    req_len;
        logic [OFF_W-1:0]    offset;
        logic [DATA_W-1:0]   data_in;
    } t_req;

    typedef struct packed {
        logic [LEN_W-1:0]    done_len;
        logic [DATA_W-1:0]   data_out;
        logic [FILL_W-1:0]   fill_level;
    } t_rsp;

    // Access command broadcast to every byte lane.
    typedef struct packed {
        logic                en;
        logic                wr;
        logic [IDX_W-1:0]    start;
        logic [LEN_W-1:0]    done;
    } t_lane_cmd;

endpackage

// ----- src/brb_lane.sv -----
// One byte lane: a bank of the store holding every LANES-th byte.
module brb_lane (
    input  logic                       i_clk,
    input  logic [brb_pkg::LANE_W-1:0] i_bank,
    input  brb_pkg::t_lane_cmd         i_cmd,
    input  logic [brb_pkg::DATA_W-1:0] i_data,
    output logic [7:0]                 o_rdata
);
    import brb_pkg::*;

    logic [7:0]       r_mem [ROWS];
    logic [7:0]       r_rdata;
    logic [LANE_W-1:0] w_k;
    logic             w_act;
    logic [IDX_W-1:0] w_pos;
    logic [ROW_W-1:0] w_row;
    logic [7:0]       w_wbyte;

    // Which byte of the transfer lands in this bank.
    assign w_k     = i_bank - i_cmd.start[LANE_W-1:0];
    assign w_act   = i_cmd.en && (LEN_W'(w_k) < i_cmd.done);
    assign w_pos   = i_cmd.start + IDX_W'(w_k);
    assign w_row   = ROW_W'(w_pos >> LANE_W);
    assign w_wbyte = i_data[{w_k, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (w_act) begin
            if (i_cmd.wr) begin
                r_mem[w_row] <= w_wbyte;
            end else begin
                r_rdata <= r_mem[w_row];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/brb_merge.sv -----
// Rotates the lane read bytes back into transfer order and zeroes unused bytes.
module brb_merge (
    input  logic [brb_pkg::LANES-1:0][7:0] i_lane_data,
    input  logic [brb_pkg::LANE_W-1:0]     i_rot,
    input  logic [brb_pkg::LEN_W-1:0]      i_len,
    output logic [brb_pkg::DATA_W-1:0]     o_data
);
    import brb_pkg::*;

    always_comb begin
        logic [LANE_W-1:0] v_bank;
        o_data = '0;
        for (int k = 0; k < LANES; k++) begin
            v_bank = i_rot + LANE_W'(k);
            if (LEN_W'(k) < i_len) begin
                o_data[8*k +: 8] = i_lane_data[v_bank];
            end
        end
    end

endmodule

// ----- src/byte_ring_buffer_unit.sv -----
// Byte FIFO over a banked ring store with free-running read and write counters.
//
// Usage: raise i_start with a request on i_req while o_busy is low; the
// request is taken at that clock edge. Modes are write, read and peek of up
// to LANES bytes, the first byte in the low byte, plus a no-op mode. A write
// stores as many bytes as fit, a read removes as many as are in use, a peek
// copies from an offset past the read position without moving the counters.
// Each request yields exactly one result on o_rsp, marked by o_valid for one
// cycle. The acceptance edge updates the counters and latches the request,
// the access state drives all byte lanes at once (each lane is a bank with
// one access per cycle), the merge state merges the lane bytes into the
// output register. o_busy stays high in the access and merge states, so a
// new request is taken only after the previous one is merged; the next may
// start in the cycle its predecessor's result is shown.
// Reset clears both counters (empty FIFO) and the control state; the byte
// store itself is not cleared. The receiver cannot stall: o_rsp holds each
// result until the next one is merged.
module byte_ring_buffer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  brb_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output brb_pkg::t_rsp o_rsp
);
    import brb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_MERGE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_wcnt;
    logic [CNT_W-1:0]  r_rcnt;
    logic              r_wr;
    logic              r_rd;
    logic [IDX_W-1:0]  r_start;
    logic [LEN_W-1:0]  r_done;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_fill;
    logic              r_valid;
    t_rsp              r_rsp;

    logic              w_accept;
    logic [CNT_W-1:0]  w_fill;
    logic [LEN_W-1:0]  w_req;
    logic [CNT_W-1:0]  w_space;
    logic [CNT_W-1:0]  w_left;
    logic              w_off_ok;
    logic [LEN_W-1:0]  w_done;
    logic [IDX_W-1:0]  w_start;
    logic [CNT_W-1:0]  n_wcnt;
    logic [CNT_W-1:0]  n_rcnt;
    logic [CNT_W-1:0]  n_fill;

    t_lane_cmd              w_cmd;
    logic [LANES-1:0][7:0]  w_lane_data;
    logic [DATA_W-1:0]      w_merged;

    function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [LEN_W-1:0] v_res;
        v_res = (32'(a) < 32'(b)) ? a : LEN_W'(b);
        return v_res;
    endfunction

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_fill   = r_wcnt - r_rcnt;
    assign w_req    = (32'(i_req.req_len) > 32'(LANES)) ? LEN_W'(LANES) : i_req.req_len;
    assign w_space  = CNT_W'(DEPTH) - w_fill;
    assign w_off_ok = 32'(i_req.offset) <= 32'(w_fill);
    assign w_left   = w_fill - CNT_W'(i_req.offset);

    always_comb begin
        w_done  = '0;
        w_start = '0;
        n_wcnt  = r_wcnt;
        n_rcnt  = r_rcnt;
        n_fill  = w_fill;
        case (i_req.mode)
            MODE_WRITE: begin
                w_done  = min_len(w_req, w_space);
                w_start = r_wcnt[IDX_W-1:0];
                n_wcnt  = r_wcnt + CNT_W'(w_done);
                n_fill  = w_fill + CNT_W'(w_done);
            end
            MODE_READ: begin
                w_done  = min_len(w_req, w_fill);
                w_start = r_rcnt[IDX_W-1:0];
                n_rcnt  = r_rcnt + CNT_W'(w_done);
                n_fill  = w_fill - CNT_W'(w_done);
            end
            MODE_PEEK: begin
                w_done  = w_off_ok ? min_len(w_req, w_left) : '0;
                w_start = r_rcnt[IDX_W-1:0] + IDX_W'(i_req.offset);
            end
            default: begin
                w_done  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wcnt  <= '0;
            r_rcnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_MERGE);
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wcnt  <= n_wcnt;
                        r_rcnt  <= n_rcnt;
                        r_state <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    r_state <= ST_MERGE;
                end
                ST_MERGE: begin
                    r_rsp.done_len   <= r_done;
                    r_rsp.data_out   <= w_merged;
                    r_rsp.fill_level <= FILL_W'(r_fill);
                    r_state          <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wr    <= (i_req.mode == MODE_WRITE);
            r_rd    <= (i_req.mode == MODE_READ) || (i_req.mode == MODE_PEEK);
            r_start <= w_start;
            r_done  <= w_done;
            r_data  <= i_req.data_in;
            r_fill  <= n_fill;
        end
    end

    assign w_cmd.en    = (r_state == ST_ACCESS) && (r_wr || r_rd);
    assign w_cmd.wr    = r_wr;
    assign w_cmd.start = r_start;
    assign w_cmd.done  = r_done;

    for (genvar b = 0; b < LANES; b++) begin : g_lane
        brb_lane u_lane (
            .i_clk   (i_clk),
            .i_bank  (LANE_W'(b)),
            .i_cmd   (w_cmd),
            .i_data  (r_data),
            .o_rdata (w_lane_data[b])
        );
    end

    brb_merge u_merge (
        .i_lane_data (w_lane_data),
        .i_rot       (r_start[LANE_W-1:0]),
        .i_len       (r_rd ? r_done : LEN_W'(0)),
        .o_data      (w_merged)
    );

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- test/brb_fifo_checker.sv -----
// Watches the byte FIFO request and result channels and checks each result.
`timescale 1ns / 1ps

module brb_fifo_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  brb_pkg::t_req i_req,
    input  logic          i_valid,
    input  brb_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);
    import brb_pkg::*;

    logic [7:0]       fifo_bytes [DEPTH];
    logic [CNT_W-1:0] wr_count;
    logic [CNT_W-1:0] rd_count;
    t_rsp             rsp_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        wr_count     = '0;
        rd_count     = '0;
    end

    function automatic int unsigned occupancy();
        return int'(CNT_W'(wr_count - rd_count));
    endfunction

    // Apply one request to the FIFO image and return the result it must give.
    function automatic t_rsp fifo_access(t_req r);
        t_rsp        rsp;
        int unsigned len;
        int unsigned fill;
        int unsigned lim;
        int unsigned base;
        rsp  = '0;
        len  = (r.req_len > LANES) ? LANES : r.req_len;
        fill = occupancy();
        lim  = 0;
        case (r.mode)
            MODE_WRITE: begin
                lim = (len < DEPTH - fill) ? len : DEPTH - fill;
                for (int i = 0; i < lim; i++)
                    fifo_bytes[IDX_W'(wr_count + i)] = r.data_in[8*i +: 8];
                wr_count = CNT_W'(wr_count + lim);
            end
            MODE_READ: begin
                lim = (len < fill) ? len : fill;
                for (int i = 0; i < lim; i++)
                    rsp.data_out[8*i +: 8] = fifo_bytes[IDX_W'(rd_count + i)];
                rd_count = CNT_W'(rd_count + lim);
            end
            MODE_PEEK: begin
                // an offset at or past the fill level copies nothing
                if (r.offset <= fill) begin
                    lim  = (len < fill - r.offset) ? len : fill - r.offset;
                    base = rd_count + r.offset;
                    for (int i = 0; i < lim; i++)
                        rsp.data_out[8*i +: 8] = fifo_bytes[IDX_W'(base + i)];
                end
            end
            default: begin
            end
        endcase
        rsp.done_len   = LEN_W'(lim);
        rsp.fill_level = FILL_W'(occupancy());
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (!i_rst_n) begin
            wr_count = '0;
            rd_count = '0;
            rsp_queue.delete();
        end else begin
            // a result shown in the same cycle as a new transfer belongs to an older one
            if (i_valid) begin
                if (rsp_queue.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp.done_len !== want.done_len) begin
                        $error("done_len: expected %0d, actual %0d",
                               want.done_len, i_rsp.done_len);
                        o_fail_count++;
                    end
                    if (i_rsp.data_out !== want.data_out) begin
                        $error("data_out: expected %h, actual %h",
                               want.data_out, i_rsp.data_out);
                        o_fail_count++;
                    end
                    if (i_rsp.fill_level !== want.fill_level) begin
                        $error("fill_level: expected %0d, actual %0d",
                               want.fill_level, i_rsp.fill_level);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                rsp_queue.push_back(fifo_access(i_req));
        end
        o_pending = rsp_queue.size();
    end

endmodule

// ----- test/tb_byte_ring_buffer_unit.sv -----
// Stimulus and verdict for the byte ring buffer FIFO.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_unit;
    import brb_pkg::*;

    localparam int REQ_W = $bits(t_req);

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_start;
    t_req  i_req;
    logic  o_busy;
    logic  o_valid;
    t_rsp  o_rsp;
    int    fail_count;
    int    pend_count;
    bit    steady;

    always #4 i_clk = ~i_clk;

    byte_ring_buffer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    brb_fifo_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pend_count)
    );

    function automatic t_req fifo_cmd(t_mode mode, int unsigned len, int unsigned off,
                                      logic [DATA_W-1:0] data);
        t_req r;
        r.mode    = mode;
        r.req_len = LEN_W'(len);
        r.offset  = OFF_W'(off);
        r.data_in = data;
        return r;
    endfunction

    // Random request; wr_pct and rd_pct bias the mix toward filling or draining.
    function automatic t_req random_cmd(int unsigned wr_pct, int unsigned rd_pct);
        t_req        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < wr_pct)
            r.mode = MODE_WRITE;
        else if (pick < wr_pct + rd_pct)
            r.mode = MODE_READ;
        else if (pick < 97)
            r.mode = MODE_PEEK;
        else
            r.mode = MODE_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.req_len = '0;
        else if (pick < 14)
            r.req_len = LEN_W'($urandom_range(LANES + 1, 15));
        else if (pick < 60)
            r.req_len = LEN_W'(LANES);
        else
            r.req_len = LEN_W'($urandom_range(1, LANES - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.offset = OFF_W'($urandom_range(0, 16));
        else if (pick < 80)
            r.offset = OFF_W'($urandom_range(0, DEPTH));
        else
            r.offset = OFF_W'($urandom_range(0, 2047));
        r.data_in = {$urandom, $urandom};
        return r;
    endfunction

    // Drive one request from a falling edge and hold it until the transfer.
    task automatic send_cmd(t_req r);
        int unsigned gap;
        if (!steady && $urandom_range(0, 99) < 26) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_start <= 1'b0;
                i_req   <= t_req'(REQ_W'({$urandom, $urandom, $urandom}));
            end
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic run_phase(int unsigned count, int unsigned wr_pct, int unsigned rd_pct);
        repeat (count) send_cmd(random_cmd(wr_pct, rd_pct));
    endtask

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        steady  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty FIFO corners
        send_cmd(fifo_cmd(MODE_READ,  8,    0, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  8,    0, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  8, 2047, '1));
        send_cmd(fifo_cmd(MODE_NONE, 15, 2047, '1));
        send_cmd(fifo_cmd(MODE_WRITE, 0,    0, '1));
        // fill to 19 bytes, one oversized write among them
        send_cmd(fifo_cmd(MODE_WRITE, 8,    0, 64'h8877_6655_4433_2211));
        send_cmd(fifo_cmd(MODE_WRITE, 15,   0, '1));
        send_cmd(fifo_cmd(MODE_WRITE, 3,    0, 64'h0000_0000_00a5_5a3c));
        // peeks: inside, oversized, running into the end, at and past the fill level
        send_cmd(fifo_cmd(MODE_PEEK,  8,    0, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  15,   5, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  4,   16, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  8,   19, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  8,   20, '0));
        send_cmd(fifo_cmd(MODE_NONE,  8,    3, {$urandom, $urandom}));
        // reads: single, oversized, zero length, then draining past empty
        send_cmd(fifo_cmd(MODE_READ,  1,    0, '0));
        send_cmd(fifo_cmd(MODE_READ,  15,   0, '0));
        send_cmd(fifo_cmd(MODE_READ,  0,    0, '0));
        send_cmd(fifo_cmd(MODE_READ,  8,    0, '0));
        send_cmd(fifo_cmd(MODE_READ,  8,    0, '0));
        send_cmd(fifo_cmd(MODE_READ,  4,    0, '0));
        send_cmd(fifo_cmd(MODE_WRITE, 8,    0, '0));
        send_cmd(fifo_cmd(MODE_PEEK,  8, 1024, '0));

        // fill to full, drain to empty, refill without idling, then a mixed run
        run_phase(200, 90, 3);
        run_phase(200, 3, 90);
        steady = 1'b1;
        run_phase(200, 90, 3);
        steady = 1'b0;
        run_phase(150, 45, 40);

        @(negedge i_clk);
        i_start <= 1'b0;
        for (int n = 0; n < 100 && pend_count != 0; n++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && pend_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
